[hw/rtl/qau_pkg.sv]
// Shared types and constants for the quaternion arithmetic unit.
package qau_pkg;

    localparam int DATA_W = 32;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        OP_PRODUCT = 3'd0,
        OP_ROTATE  = 3'd1,
        OP_ADD     = 3'd2,
        OP_SUB     = 3'd3,
        OP_NEG     = 3'd4,
        OP_SCALE   = 3'd5
    } qau_op_t;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_W-1:0] a_x;
        logic signed [DATA_W-1:0] a_y;
        logic signed [DATA_W-1:0] a_z;
        logic signed [DATA_W-1:0] a_w;
        logic signed [DATA_W-1:0] b_x;
        logic signed [DATA_W-1:0] b_y;
        logic signed [DATA_W-1:0] b_z;
        logic signed [DATA_W-1:0] b_w;
    } qau_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_x;
        logic signed [DATA_W-1:0] res_y;
        logic signed [DATA_W-1:0] res_z;
        logic signed [DATA_W-1:0] res_w;
        logic                     overflow;
    } qau_out_t;

endpackage

[hw/rtl/qau_mulq.sv]
// Registered fixed-point multiply: full signed product, floor-shifted by the fraction width.
module qau_mulq #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [qau_pkg::DATA_W-1:0]   a,
    input  logic signed [qau_pkg::DATA_W-1:0]   b,
    output logic signed [2*qau_pkg::DATA_W-FRAC_BITS-1:0] p
);
    import qau_pkg::*;

    localparam int FULL_W = 2 * DATA_W;

    logic signed [FULL_W-1:0]          full;
    logic signed [FULL_W-FRAC_BITS-1:0] p_reg;

    assign full = FULL_W'(a) * FULL_W'(b);

    // dropping the low bits is an arithmetic shift, i.e. floor
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= full[FULL_W-1:FRAC_BITS];
        end
    end

    assign p = p_reg;

endmodule

[hw/rtl/quaternion_arithmetic_unit.sv]
// Quaternion arithmetic unit top level: six-stage pipeline with two multiplier banks.
//
// Fixed-point quaternion unit, signed Q(32-FRAC_BITS).FRAC_BITS. Each transaction carries an
// opcode, quaternion A and operand B and returns one saturated result: Hamilton product,
// rotation of B.xyz by A, add, subtract, negate, or scale of A by b_w. The pipeline takes a
// transaction every cycle unless all stages are full and m_ready is low. The input register
// loads at the accepting edge, and the transaction moves through the stage registers to the
// output register, which drives m_valid. Sixteen 32x32 multipliers form every first-level
// product in stage 2; nine more form the second-level rotation products in stage 4. Stalls
// propagate stage by stage, so empty stages still accept while a result waits at the output.
module quaternion_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  qau_pkg::qau_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output qau_pkg::qau_out_t m_item
);
    import qau_pkg::*;

    localparam int NSTAGE = 6;
    localparam int PW     = 2 * DATA_W - FRAC_BITS;   // width of one shifted product
    localparam int SW     = PW + 4;                   // width of every pre-saturation sum
    localparam int NM1    = 16;
    localparam int NM2    = 9;

    function automatic logic fits32(input logic signed [SW-1:0] v);
        return (v[SW-1:DATA_W-1] == '0) || (v[SW-1:DATA_W-1] == '1);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SW-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (fits32(v)) begin
            r = v[DATA_W-1:0];
        end else if (v[SW-1]) begin
            r = S32_MIN;
        end else begin
            r = S32_MAX;
        end
        return r;
    endfunction

    // ---------------- flow control ----------------
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] adv;

    always_comb begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[NSTAGE-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (adv[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: input register ----------------
    qau_in_t s1_in_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s1_in_reg <= s_item;
        end
    end

    // ---------------- stage 2: first multiplier bank ----------------
    logic signed [DATA_W-1:0] m1_a [NM1];
    logic signed [DATA_W-1:0] m1_b [NM1];
    logic signed [PW-1:0]     p1   [NM1];
    qau_in_t                  s2_in_reg;

    // x: aw*bx ax*bw ay*bz az*by | y: aw*by ay*bw az*bx ax*bz
    // z: aw*bz az*bw ax*by ay*bx | w: aw*bw ax*bx ay*by az*bz
    always_comb begin
        m1_a[0]  = s1_in_reg.a_w; m1_b[0]  = s1_in_reg.b_x;
        m1_a[1]  = s1_in_reg.a_x; m1_b[1]  = s1_in_reg.b_w;
        m1_a[2]  = s1_in_reg.a_y; m1_b[2]  = s1_in_reg.b_z;
        m1_a[3]  = s1_in_reg.a_z; m1_b[3]  = s1_in_reg.b_y;
        m1_a[4]  = s1_in_reg.a_w; m1_b[4]  = s1_in_reg.b_y;
        m1_a[5]  = s1_in_reg.a_y; m1_b[5]  = s1_in_reg.b_w;
        m1_a[6]  = s1_in_reg.a_z; m1_b[6]  = s1_in_reg.b_x;
        m1_a[7]  = s1_in_reg.a_x; m1_b[7]  = s1_in_reg.b_z;
        m1_a[8]  = s1_in_reg.a_w; m1_b[8]  = s1_in_reg.b_z;
        m1_a[9]  = s1_in_reg.a_z; m1_b[9]  = s1_in_reg.b_w;
        m1_a[10] = s1_in_reg.a_x; m1_b[10] = s1_in_reg.b_y;
        m1_a[11] = s1_in_reg.a_y; m1_b[11] = s1_in_reg.b_x;
        m1_a[12] = s1_in_reg.a_w; m1_b[12] = s1_in_reg.b_w;
        m1_a[13] = s1_in_reg.a_x; m1_b[13] = s1_in_reg.b_x;
        m1_a[14] = s1_in_reg.a_y; m1_b[14] = s1_in_reg.b_y;
        m1_a[15] = s1_in_reg.a_z; m1_b[15] = s1_in_reg.b_z;
    end

    for (genvar i = 0; i < NM1; i++) begin : g_bank1
        qau_mulq #(
            .FRAC_BITS (FRAC_BITS)
        ) u_mul (
            .aclk (aclk),
            .en   (adv[1]),
            .a    (m1_a[i]),
            .b    (m1_b[i]),
            .p    (p1[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s2_in_reg <= s1_in_reg;
        end
    end

    // ---------------- stage 3: first sums, cross product q x v ----------------
    logic signed [SW-1:0]     wide3 [4];
    logic signed [SW-1:0]     d3    [3];
    logic signed [DATA_W-1:0] u3    [3];
    logic                     ovf3;

    logic signed [SW-1:0]     s3_wide_reg [4];
    logic signed [DATA_W-1:0] s3_u_reg    [3];
    logic                     s3_ovf_reg;
    qau_in_t                  s3_in_reg;

    always_comb begin
        d3[0] = SW'(p1[2])  - SW'(p1[3]);
        d3[1] = SW'(p1[6])  - SW'(p1[7]);
        d3[2] = SW'(p1[10]) - SW'(p1[11]);
        for (int i = 0; i < 3; i++) begin
            u3[i] = sat32(d3[i]);
        end
        ovf3 = 1'b0;
        for (int i = 0; i < 4; i++) begin
            wide3[i] = '0;
        end
        unique case (qau_op_t'(s2_in_reg.func))
            OP_PRODUCT: begin
                wide3[0] = SW'(p1[0]) + SW'(p1[1]) + SW'(p1[2]) - SW'(p1[3]);
                wide3[1] = SW'(p1[4]) + SW'(p1[5]) + SW'(p1[6]) - SW'(p1[7]);
                wide3[2] = SW'(p1[8]) + SW'(p1[9]) + SW'(p1[10]) - SW'(p1[11]);
                wide3[3] = SW'(p1[12]) - SW'(p1[13]) - SW'(p1[14]) - SW'(p1[15]);
            end
            OP_ROTATE: begin
                ovf3 = !fits32(d3[0]) || !fits32(d3[1]) || !fits32(d3[2]);
            end
            OP_ADD: begin
                wide3[0] = SW'(s2_in_reg.a_x) + SW'(s2_in_reg.b_x);
                wide3[1] = SW'(s2_in_reg.a_y) + SW'(s2_in_reg.b_y);
                wide3[2] = SW'(s2_in_reg.a_z) + SW'(s2_in_reg.b_z);
                wide3[3] = SW'(s2_in_reg.a_w) + SW'(s2_in_reg.b_w);
            end
            OP_SUB: begin
                wide3[0] = SW'(s2_in_reg.a_x) - SW'(s2_in_reg.b_x);
                wide3[1] = SW'(s2_in_reg.a_y) - SW'(s2_in_reg.b_y);
                wide3[2] = SW'(s2_in_reg.a_z) - SW'(s2_in_reg.b_z);
                wide3[3] = SW'(s2_in_reg.a_w) - SW'(s2_in_reg.b_w);
            end
            OP_NEG: begin
                wide3[0] = -SW'(s2_in_reg.a_x);
                wide3[1] = -SW'(s2_in_reg.a_y);
                wide3[2] = -SW'(s2_in_reg.a_z);
                wide3[3] = -SW'(s2_in_reg.a_w);
            end
            OP_SCALE: begin
                wide3[0] = SW'(p1[1]);
                wide3[1] = SW'(p1[5]);
                wide3[2] = SW'(p1[9]);
                wide3[3] = SW'(p1[12]);
            end
            default: begin
                ovf3 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s3_wide_reg <= wide3;
            s3_u_reg    <= u3;
            s3_ovf_reg  <= ovf3;
            s3_in_reg   <= s2_in_reg;
        end
    end

    // ---------------- stage 4: second multiplier bank (rotation) ----------------
    logic signed [DATA_W-1:0] m2_a [NM2];
    logic signed [DATA_W-1:0] m2_b [NM2];
    logic signed [PW-1:0]     p2   [NM2];

    logic signed [SW-1:0]     s4_wide_reg [4];
    logic                     s4_ovf_reg;
    logic [2:0]               s4_func_reg;
    logic signed [DATA_W-1:0] s4_b_reg    [3];

    // q x u terms, then u*aw
    always_comb begin
        m2_a[0] = s3_in_reg.a_y; m2_b[0] = s3_u_reg[2];
        m2_a[1] = s3_in_reg.a_z; m2_b[1] = s3_u_reg[1];
        m2_a[2] = s3_in_reg.a_z; m2_b[2] = s3_u_reg[0];
        m2_a[3] = s3_in_reg.a_x; m2_b[3] = s3_u_reg[2];
        m2_a[4] = s3_in_reg.a_x; m2_b[4] = s3_u_reg[1];
        m2_a[5] = s3_in_reg.a_y; m2_b[5] = s3_u_reg[0];
        m2_a[6] = s3_u_reg[0];   m2_b[6] = s3_in_reg.a_w;
        m2_a[7] = s3_u_reg[1];   m2_b[7] = s3_in_reg.a_w;
        m2_a[8] = s3_u_reg[2];   m2_b[8] = s3_in_reg.a_w;
    end

    for (genvar i = 0; i < NM2; i++) begin : g_bank2
        qau_mulq #(
            .FRAC_BITS (FRAC_BITS)
        ) u_mul (
            .aclk (aclk),
            .en   (adv[3]),
            .a    (m2_a[i]),
            .b    (m2_b[i]),
            .p    (p2[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s4_wide_reg <= s3_wide_reg;
            s4_ovf_reg  <= s3_ovf_reg;
            s4_func_reg <= s3_in_reg.func;
            s4_b_reg[0] <= s3_in_reg.b_x;
            s4_b_reg[1] <= s3_in_reg.b_y;
            s4_b_reg[2] <= s3_in_reg.b_z;
        end
    end

    // ---------------- stage 5: rotation sums v + 2*(w*u + q x u) ----------------
    logic signed [SW-1:0] wide5 [4];
    logic signed [SW-1:0] t5    [3];

    logic signed [SW-1:0] s5_wide_reg [4];
    logic                 s5_ovf_reg;

    always_comb begin
        t5[0] = SW'(p2[6]) + SW'(p2[0]) - SW'(p2[1]);
        t5[1] = SW'(p2[7]) + SW'(p2[2]) - SW'(p2[3]);
        t5[2] = SW'(p2[8]) + SW'(p2[4]) - SW'(p2[5]);
        wide5 = s4_wide_reg;
        if (qau_op_t'(s4_func_reg) == OP_ROTATE) begin
            for (int i = 0; i < 3; i++) begin
                wide5[i] = SW'(s4_b_reg[i]) + (t5[i] <<< 1);
            end
            wide5[3] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s5_wide_reg <= wide5;
            s5_ovf_reg  <= s4_ovf_reg;
        end
    end

    // ---------------- stage 6: saturation, output register ----------------
    qau_out_t out_next;
    qau_out_t out_reg;

    always_comb begin
        out_next.res_x    = sat32(s5_wide_reg[0]);
        out_next.res_y    = sat32(s5_wide_reg[1]);
        out_next.res_z    = sat32(s5_wide_reg[2]);
        out_next.res_w    = sat32(s5_wide_reg[3]);
        out_next.overflow = s5_ovf_reg
                            || !fits32(s5_wide_reg[0]) || !fits32(s5_wide_reg[1])
                            || !fits32(s5_wide_reg[2]) || !fits32(s5_wide_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            out_reg <= out_next;
        end
    end

    assign m_item = out_reg;

endmodule

[bench/qau_checker.sv]
// Checker for the quaternion arithmetic unit: predicts each result and compares it.
`timescale 1ns / 100ps

module qau_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  qau_pkg::qau_in_t  s_item,
    input  logic              m_valid,
    input  logic              m_ready,
    input  qau_pkg::qau_out_t m_item,
    output int                failures,
    output int                outstanding
);
    import qau_pkg::*;

    qau_out_t quat_results_q[$];
    qau_out_t want;
    int       result_idx;

    // Product of two Q values; >>> on a signed 64-bit value floors toward minus infinity.
    function automatic longint fx_mul(input longint a, input longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp32(input longint v, inout bit ovf);
        if (v > longint'(S32_MAX)) begin
            ovf = 1'b1;
            return longint'(S32_MAX);
        end
        if (v < longint'(S32_MIN)) begin
            ovf = 1'b1;
            return longint'(S32_MIN);
        end
        return v;
    endfunction

    function automatic qau_out_t quat_result(input qau_in_t it);
        longint   ax, ay, az, aw, bx, by, bz, bw;
        longint   rx, ry, rz, rw;
        longint   ux, uy, uz, wx, wy, wz;
        bit       ovf;
        qau_out_t r;
        ax = $signed(it.a_x);
        ay = $signed(it.a_y);
        az = $signed(it.a_z);
        aw = $signed(it.a_w);
        bx = $signed(it.b_x);
        by = $signed(it.b_y);
        bz = $signed(it.b_z);
        bw = $signed(it.b_w);
        rx = 0;
        ry = 0;
        rz = 0;
        rw = 0;
        ovf = 1'b0;
        case (it.func)
            OP_PRODUCT: begin
                rx = fx_mul(aw, bx) + fx_mul(ax, bw) + fx_mul(ay, bz) - fx_mul(az, by);
                ry = fx_mul(aw, by) + fx_mul(ay, bw) + fx_mul(az, bx) - fx_mul(ax, bz);
                rz = fx_mul(aw, bz) + fx_mul(az, bw) + fx_mul(ax, by) - fx_mul(ay, bx);
                rw = fx_mul(aw, bw) - fx_mul(ax, bx) - fx_mul(ay, by) - fx_mul(az, bz);
            end
            OP_ROTATE: begin
                // q x v is clamped before it feeds the second cross product
                ux = clamp32(fx_mul(ay, bz) - fx_mul(az, by), ovf);
                uy = clamp32(fx_mul(az, bx) - fx_mul(ax, bz), ovf);
                uz = clamp32(fx_mul(ax, by) - fx_mul(ay, bx), ovf);
                wx = fx_mul(ay, uz) - fx_mul(az, uy);
                wy = fx_mul(az, ux) - fx_mul(ax, uz);
                wz = fx_mul(ax, uy) - fx_mul(ay, ux);
                rx = bx + 2 * (fx_mul(ux, aw) + wx);
                ry = by + 2 * (fx_mul(uy, aw) + wy);
                rz = bz + 2 * (fx_mul(uz, aw) + wz);
            end
            OP_ADD: begin
                rx = ax + bx;
                ry = ay + by;
                rz = az + bz;
                rw = aw + bw;
            end
            OP_SUB: begin
                rx = ax - bx;
                ry = ay - by;
                rz = az - bz;
                rw = aw - bw;
            end
            OP_NEG: begin
                rx = -ax;
                ry = -ay;
                rz = -az;
                rw = -aw;
            end
            OP_SCALE: begin
                rx = fx_mul(ax, bw);
                ry = fx_mul(ay, bw);
                rz = fx_mul(az, bw);
                rw = fx_mul(aw, bw);
            end
            default: ;
        endcase
        r.res_x = 32'(clamp32(rx, ovf));
        r.res_y = 32'(clamp32(ry, ovf));
        r.res_z = 32'(clamp32(rz, ovf));
        r.res_w = 32'(clamp32(rw, ovf));
        r.overflow = ovf;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("[%0t] result %0d: %s got %0d, want %0d", $time, result_idx, what, got,
                 exp_val);
        failures++;
    endtask

    initial begin
        failures = 0;
        outstanding = 0;
        result_idx = 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                quat_results_q.push_back(quat_result(s_item));
            end
            if (m_valid && m_ready) begin
                if (quat_results_q.size() == 0) begin
                    report_mismatch("transaction with nothing pending, res_x", m_item.res_x, 0);
                end else begin
                    want = quat_results_q.pop_front();
                    if (m_item.res_x !== want.res_x)
                        report_mismatch("res_x", m_item.res_x, want.res_x);
                    if (m_item.res_y !== want.res_y)
                        report_mismatch("res_y", m_item.res_y, want.res_y);
                    if (m_item.res_z !== want.res_z)
                        report_mismatch("res_z", m_item.res_z, want.res_z);
                    if (m_item.res_w !== want.res_w)
                        report_mismatch("res_w", m_item.res_w, want.res_w);
                    if (m_item.overflow !== want.overflow)
                        report_mismatch("overflow", m_item.overflow, want.overflow);
                end
                result_idx++;
            end
            outstanding = quat_results_q.size();
        end
    end

endmodule

[bench/tb_top.sv]
// Testbench top: stimulus, flow control and verdict for the quaternion arithmetic unit.
`timescale 1ns / 100ps

module tb_top;
    import qau_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;

    localparam logic [2:0] OP_UNDEF_6 = 3'd6;
    localparam logic [2:0] OP_UNDEF_7 = 3'd7;

    localparam logic signed [31:0] ONE   = 32'sh0001_0000;
    localparam logic signed [31:0] HALF  = 32'sh0000_8000;
    localparam logic signed [31:0] SIN45 = 32'sd46341;
    localparam logic signed [31:0] MAXV  = S32_MAX;
    localparam logic signed [31:0] MINV  = S32_MIN;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    qau_in_t  s_item;
    logic     m_valid;
    logic     m_ready;
    qau_out_t m_item;
    int       failures;
    int       outstanding;
    int       cycle_cnt;
    bit       idle_en;
    bit       hold_req;

    quaternion_arithmetic_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    qau_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("quaternion_arithmetic_unit test failed");
            $finish;
        end
    end

    function automatic qau_in_t mk_item(
        input logic [2:0] f,
        input logic signed [31:0] ax, ay, az, aw,
        input logic signed [31:0] bx, by, bz, bw
    );
        qau_in_t it;
        it.func = f;
        it.a_x = ax;
        it.a_y = ay;
        it.a_z = az;
        it.a_w = aw;
        it.b_x = bx;
        it.b_y = by;
        it.b_z = bz;
        it.b_w = bw;
        return it;
    endfunction

    // One operand component: full range, small (within +-2.0), moderate (within +-16.0), or a corner value
    function automatic logic signed [31:0] rand_comp(input int mode);
        int pick;
        pick = (mode == 3) ? $urandom_range(0, 3) : mode;
        case (pick)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
            2: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: begin
                case ($urandom_range(0, 5))
                    0: return MAXV;
                    1: return MINV;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    4: return ONE;
                    default: return -ONE;
                endcase
            end
        endcase
    endfunction

    function automatic qau_in_t rand_item();
        qau_in_t it;
        int      r;
        int      mode;
        r = $urandom_range(0, 15);
        mode = $urandom_range(0, 3);
        if (r < 14)
            it.func = 3'(r % 6);
        else
            it.func = (r == 14) ? OP_UNDEF_6 : OP_UNDEF_7;
        it.a_x = rand_comp(mode);
        it.a_y = rand_comp(mode);
        it.a_z = rand_comp(mode);
        it.a_w = rand_comp(mode);
        it.b_x = rand_comp(mode);
        it.b_y = rand_comp(mode);
        it.b_z = rand_comp(mode);
        it.b_w = rand_comp(mode);
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send(input qau_in_t it);
        while (idle_en && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (idle_en) begin
                m_ready <= ($urandom_range(0, 99) >= 8);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        cycle_cnt = 0;
        idle_en = 1'b1;
        hold_req = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed corners
        send(mk_item(OP_PRODUCT, 0, 0, 0, ONE, 2 * ONE, -ONE, 3 * ONE, HALF));
        send(mk_item(OP_PRODUCT, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV));
        send(mk_item(OP_PRODUCT, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
        send(mk_item(OP_PRODUCT, -1, -1, -1, -1, 1, 1, 1, 1));
        send(mk_item(OP_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk_item(OP_ROTATE, 0, 0, SIN45, SIN45, ONE, 0, 0, 0));
        send(mk_item(OP_ROTATE, MAXV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV, MINV));
        send(mk_item(OP_ROTATE, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
        send(mk_item(OP_ADD, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
        send(mk_item(OP_ADD, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
        send(mk_item(OP_ADD, MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV));
        send(mk_item(OP_SUB, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV));
        send(mk_item(OP_SUB, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV));
        send(mk_item(OP_SUB, ONE, -ONE, HALF, 0, HALF, ONE, -HALF, 1));
        send(mk_item(OP_NEG, MINV, MINV, MINV, MINV, 0, 0, 0, 0));
        send(mk_item(OP_NEG, MAXV, 1, -1, 0, MINV, MAXV, -1, ONE));
        send(mk_item(OP_NEG, 0, 0, 0, 0, MAXV, MAXV, MAXV, MAXV));
        send(mk_item(OP_SCALE, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, -ONE));
        send(mk_item(OP_SCALE, MAXV, MAXV, MAXV, MAXV, MINV, 0, -1, MAXV));
        send(mk_item(OP_SCALE, MAXV, MINV, ONE, -ONE, 0, 0, 0, 0));
        send(mk_item(OP_UNDEF_6, MAXV, MINV, ONE, -1, MINV, MAXV, -1, ONE));
        send(mk_item(OP_UNDEF_7, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));

        // sender pauses until the pipeline is empty
        drain();

        // long output hold-off while input keeps coming, so the pipeline backs up
        hold_req = 1'b1;
        repeat (60) send(rand_item());

        // back-to-back stretch with no idling on either side
        idle_en = 1'b0;
        repeat (150) send(rand_item());
        idle_en = 1'b1;

        repeat (520) send(rand_item());

        drain();
        repeat (12) @(negedge aclk);
        if (failures == 0)
            $display("quaternion_arithmetic_unit test passed");
        else
            $display("quaternion_arithmetic_unit test failed");
        $finish;
    end

endmodule
